[rtl/core/bdrs_pkg.sv]
// shared types, constants and state codes of the bloom dedup reservoir sampler
`timescale 1ns / 1ps

package bdrs_pkg;

   // filter geometry
   localparam int FILTER_INDEX_BITS = 15;
   localparam int FILTER_DEPTH      = 1 << FILTER_INDEX_BITS;

   // reservoir pool geometry
   localparam int POOL_DEPTH = 50;
   localparam int POOL_IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int POOL_CNT_W = $clog2(POOL_DEPTH + 1);

   // field widths
   localparam int KEY_W   = 48;
   localparam int RND_W   = 32;
   localparam int CFG_W   = 4;
   localparam int SLOT_W  = 6;
   localparam int FILL_W  = 6;
   localparam int HASH_W  = 32;
   localparam int WORD_W  = 64;
   localparam int SEEN_W  = 32;

   // probe count limits
   localparam int MAX_PROBES = 8;
   localparam int PROBE_W    = 3;

   localparam logic [CFG_W-1:0] RESET_NUM_HASHES = 4'd3;

   // mixing finalizer constants
   localparam logic [WORD_W-1:0] MUL_A  = 64'hff51afd7ed558ccd;
   localparam logic [WORD_W-1:0] MUL_B  = 64'hc4ceb9fe1a85ec53;
   localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam int                MIX_SHIFT = 33;

   typedef struct packed {
      logic [KEY_W-1:0] device_key;
      logic [RND_W-1:0] random_word;
   } req_type;

   typedef struct packed {
      logic              is_new;
      logic              pool_written;
      logic [SLOT_W-1:0] pool_slot;
      logic [FILL_W-1:0] pool_fill;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH1,
      ST_HASH2,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_SET,
      ST_UPDATE,
      ST_MOD,
      ST_RESULT
   } state_type;

endpackage

[rtl/core/bdrs_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bdrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/bdrs_hash.sv]
// 64-bit mixing finalizer on one shared 32x32 multiplier
`timescale 1ns / 1ps

module bdrs_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bdrs_pkg::WORD_W-1:0]  value,
   output logic                         done,
   output logic [bdrs_pkg::HASH_W-1:0]  result
);

   logic [bdrs_pkg::WORD_W-1:0] v_ff, v_in;
   logic [bdrs_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [bdrs_pkg::WORD_W-1:0] mul_const;
   logic [31:0]                 op_a, op_b;
   logic [63:0]                 prod;

   // cnt[2] picks the multiplier constant, cnt[1:0] the partial product step
   assign mul_const = cnt_ff[2] ? bdrs_pkg::MUL_B : bdrs_pkg::MUL_A;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            op_a = v_ff[31:0];
            op_b = mul_const[31:0];
         end
         2'd1: begin
            op_a = v_ff[31:0];
            op_b = mul_const[63:32];
         end
         2'd2: begin
            op_a = v_ff[63:32];
            op_b = mul_const[31:0];
         end
         default: begin
            op_a = v_ff[63:32];
            op_b = mul_const[63:32];
         end
      endcase
   end

   assign prod = 64'(op_a) * 64'(op_b);

   always_comb begin
      v_in    = v_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = value ^ (value >> bdrs_pkg::MIX_SHIFT);
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 3'd1;
         case (cnt_ff[1:0])
            2'd0: acc_in = prod;
            2'd1: acc_in[63:32] = acc_ff[63:32] + prod[31:0];
            2'd2: acc_in[63:32] = acc_ff[63:32] + prod[31:0];
            default: begin
               v_in = acc_ff ^ (acc_ff >> bdrs_pkg::MIX_SHIFT);
               if (cnt_ff == 3'd7) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = v_ff[bdrs_pkg::HASH_W-1:0];

endmodule

[rtl/core/bdrs_mod.sv]
// bit-serial restoring remainder, one dividend bit per cycle
`timescale 1ns / 1ps

module bdrs_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bdrs_pkg::SEEN_W-1:0] dividend,
   input  logic [bdrs_pkg::SEEN_W-1:0] divisor,
   output logic                        done,
   output logic [bdrs_pkg::SEEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(bdrs_pkg::SEEN_W);

   logic [bdrs_pkg::SEEN_W-1:0] rem_ff, rem_in;
   logic [bdrs_pkg::SEEN_W-1:0] num_ff, num_in;
   logic [bdrs_pkg::SEEN_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [bdrs_pkg::SEEN_W:0]   trial;
   logic [bdrs_pkg::SEEN_W:0]   diff;

   assign trial = {rem_ff, num_ff[bdrs_pkg::SEEN_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         num_in = dividend;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below the divisor, so the low bits always hold it
         rem_in = diff[bdrs_pkg::SEEN_W] ? trial[bdrs_pkg::SEEN_W-1:0]
                                         : diff[bdrs_pkg::SEEN_W-1:0];
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(bdrs_pkg::SEEN_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/bloom_dedup_reservoir_sampler.sv]
// top level: bloom filter de-duplicator with reservoir sampling of new keys
//
// usage: drive req_item and raise start; the item transfers at a clock edge with
// start high and busy low. exactly one result per item shows on rsp_item for one
// cycle with rsp_valid high; the receiver cannot stall it, so it must take it then.
// num_hashes is written over the csr channel (csr_ready is always high); the user must
// write it only while busy is low, as the block itself does not enforce this.
// after reset busy stays high while all 32768 filter ram bits are swept to zero,
// one bit per cycle; the pool count, seen counter and num_hashes (3) reset
// at once.
// work per item after the transfer, with k probes:
//   key already seen: k probe reads
//   new key:          j <= k probe reads up to the first clear bit, then k filter bit writes
//   new key, pool full: a remainder run as well
// the block takes one item at a time. the hash unit's single 32x32 multiplier
// (12 partial products per item, two finalizer passes) and the one-bit-per-cycle
// remainder unit bound the processing time, along with one filter ram port.
`timescale 1ns / 1ps

module bloom_dedup_reservoir_sampler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  bdrs_pkg::req_type          req_item,
   output logic                       rsp_valid,
   output bdrs_pkg::rsp_type          rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bdrs_pkg::CFG_W-1:0] csr_data
);

   localparam int FIB = bdrs_pkg::FILTER_INDEX_BITS;

   bdrs_pkg::state_type state_ff, state_in;

   logic [bdrs_pkg::CFG_W-1:0]      num_hashes_ff, num_hashes_in;
   logic [bdrs_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [bdrs_pkg::RND_W-1:0]      rnd_ff, rnd_in;
   logic [bdrs_pkg::PROBE_W-1:0]    last_ff, last_in;
   logic [bdrs_pkg::PROBE_W-1:0]    i_ff, i_in;
   logic [FIB-1:0]                  h1_ff, h1_in;
   logic [FIB-1:0]                  h2_ff, h2_in;
   logic [FIB-1:0]                  idx_ff, idx_in;
   logic [FIB-1:0]                  clr_ff, clr_in;
   logic [bdrs_pkg::POOL_CNT_W-1:0] pool_cnt_ff, pool_cnt_in;
   logic [bdrs_pkg::SEEN_W-1:0]     seen_ff, seen_in;
   logic                            is_new_ff, is_new_in;
   logic                            written_ff, written_in;
   logic [bdrs_pkg::POOL_IDX_W-1:0] slot_ff, slot_in;

   logic [bdrs_pkg::CFG_W-1:0]      probes_sat;
   logic [bdrs_pkg::SEEN_W-1:0]     seen_next;

   logic                            hash_start;
   logic [bdrs_pkg::WORD_W-1:0]     hash_value;
   logic                            hash_done;
   logic [bdrs_pkg::HASH_W-1:0]     hash_result;

   logic                            mod_start;
   logic                            mod_done;
   logic [bdrs_pkg::SEEN_W-1:0]     mod_rem;

   logic                            flt_wr_en;
   logic [FIB-1:0]                  flt_wr_addr;
   logic [0:0]                      flt_wr_data;
   logic [0:0]                      flt_rd_data;

   logic                            pool_wr_en;
   logic [bdrs_pkg::POOL_IDX_W-1:0] pool_wr_addr;

   bdrs_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .value  (hash_value),
      .done   (hash_done),
      .result (hash_result)
   );

   bdrs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (seen_next),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   bdrs_ram #(
      .WIDTH (1),
      .DEPTH (bdrs_pkg::FILTER_DEPTH)
   ) u_filter_ram (
      .clock   (clock),
      .wr_en   (flt_wr_en),
      .wr_addr (flt_wr_addr),
      .wr_data (flt_wr_data),
      .rd_addr (idx_ff),
      .rd_data (flt_rd_data)
   );

   // the pool is only ever written
   bdrs_ram #(
      .WIDTH (bdrs_pkg::KEY_W),
      .DEPTH (bdrs_pkg::POOL_DEPTH)
   ) u_pool_ram (
      .clock   (clock),
      .wr_en   (pool_wr_en),
      .wr_addr (pool_wr_addr),
      .wr_data (key_ff),
      .rd_addr ('0),
      .rd_data ()
   );

   assign csr_ready = 1'b1;

   // zero probes act as one, more than eight as eight
   always_comb begin
      probes_sat = num_hashes_ff;
      if (probes_sat == '0) begin
         probes_sat = bdrs_pkg::CFG_W'(1);
      end
      if (probes_sat > bdrs_pkg::CFG_W'(bdrs_pkg::MAX_PROBES)) begin
         probes_sat = bdrs_pkg::CFG_W'(bdrs_pkg::MAX_PROBES);
      end
   end

   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      num_hashes_in = num_hashes_ff;
      key_in        = key_ff;
      rnd_in        = rnd_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      pool_cnt_in   = pool_cnt_ff;
      seen_in       = seen_ff;
      is_new_in     = is_new_ff;
      written_in    = written_ff;
      slot_in       = slot_ff;
      hash_start    = 1'b0;
      hash_value    = {{(bdrs_pkg::WORD_W - bdrs_pkg::KEY_W){1'b0}}, key_ff};
      mod_start     = 1'b0;
      flt_wr_en     = 1'b0;
      flt_wr_addr   = idx_ff;
      flt_wr_data   = 1'b1;
      pool_wr_en    = 1'b0;
      pool_wr_addr  = slot_ff;
      busy          = 1'b1;
      rsp_valid     = 1'b0;

      if (csr_valid) begin
         num_hashes_in = csr_data;
      end

      case (state_ff)
         bdrs_pkg::ST_CLEAR: begin
            flt_wr_en   = 1'b1;
            flt_wr_addr = clr_ff;
            flt_wr_data = 1'b0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = bdrs_pkg::ST_IDLE;
            end
         end
         bdrs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               key_in     = req_item.device_key;
               rnd_in     = req_item.random_word;
               last_in    = bdrs_pkg::PROBE_W'(probes_sat - 1'b1);
               is_new_in  = 1'b0;
               written_in = 1'b0;
               slot_in    = '0;
               hash_start = 1'b1;
               hash_value = {{(bdrs_pkg::WORD_W - bdrs_pkg::KEY_W){1'b0}},
                             req_item.device_key};
               state_in   = bdrs_pkg::ST_HASH1;
            end
         end
         bdrs_pkg::ST_HASH1: begin
            if (hash_done) begin
               h1_in      = hash_result[FIB-1:0];
               hash_start = 1'b1;
               hash_value = {{(bdrs_pkg::WORD_W - bdrs_pkg::KEY_W){1'b0}}, key_ff}
                            ^ bdrs_pkg::GOLDEN;
               state_in   = bdrs_pkg::ST_HASH2;
            end
         end
         bdrs_pkg::ST_HASH2: begin
            if (hash_done) begin
               h2_in    = hash_result[FIB-1:0] | FIB'(1);
               idx_in   = h1_ff;
               i_in     = '0;
               state_in = bdrs_pkg::ST_PROBE_RD;
            end
         end
         bdrs_pkg::ST_PROBE_RD: begin
            // filter read issued at idx_ff, data back next cycle
            state_in = bdrs_pkg::ST_PROBE_CHK;
         end
         bdrs_pkg::ST_PROBE_CHK: begin
            if (flt_rd_data == 1'b0) begin
               is_new_in = 1'b1;
               idx_in    = h1_ff;
               i_in      = '0;
               state_in  = bdrs_pkg::ST_SET;
            end else if (i_ff == last_ff) begin
               state_in = bdrs_pkg::ST_RESULT;
            end else begin
               i_in     = i_ff + 1'b1;
               idx_in   = idx_ff + h2_ff;
               state_in = bdrs_pkg::ST_PROBE_RD;
            end
         end
         bdrs_pkg::ST_SET: begin
            flt_wr_en = 1'b1;
            i_in      = i_ff + 1'b1;
            idx_in    = idx_ff + h2_ff;
            if (i_ff == last_ff) begin
               state_in = bdrs_pkg::ST_UPDATE;
            end
         end
         bdrs_pkg::ST_UPDATE: begin
            seen_in = seen_next;
            if (pool_cnt_ff < bdrs_pkg::POOL_CNT_W'(bdrs_pkg::POOL_DEPTH)) begin
               pool_wr_en   = 1'b1;
               pool_wr_addr = pool_cnt_ff[bdrs_pkg::POOL_IDX_W-1:0];
               slot_in      = pool_cnt_ff[bdrs_pkg::POOL_IDX_W-1:0];
               written_in   = 1'b1;
               pool_cnt_in  = pool_cnt_ff + 1'b1;
               state_in     = bdrs_pkg::ST_RESULT;
            end else begin
               mod_start = 1'b1;
               state_in  = bdrs_pkg::ST_MOD;
            end
         end
         bdrs_pkg::ST_MOD: begin
            if (mod_done) begin
               if (mod_rem < bdrs_pkg::SEEN_W'(bdrs_pkg::POOL_DEPTH)) begin
                  pool_wr_en   = 1'b1;
                  pool_wr_addr = mod_rem[bdrs_pkg::POOL_IDX_W-1:0];
                  slot_in      = mod_rem[bdrs_pkg::POOL_IDX_W-1:0];
                  written_in   = 1'b1;
               end
               state_in = bdrs_pkg::ST_RESULT;
            end
         end
         bdrs_pkg::ST_RESULT: begin
            rsp_valid = 1'b1;
            state_in  = bdrs_pkg::ST_IDLE;
         end
         default: begin
            state_in = bdrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bdrs_pkg::ST_CLEAR;
         clr_ff        <= '0;
         num_hashes_ff <= bdrs_pkg::RESET_NUM_HASHES;
         pool_cnt_ff   <= '0;
         seen_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         num_hashes_ff <= num_hashes_in;
         pool_cnt_ff   <= pool_cnt_in;
         seen_ff       <= seen_in;
      end
      key_ff     <= key_in;
      rnd_ff     <= rnd_in;
      last_ff    <= last_in;
      i_ff       <= i_in;
      h1_ff      <= h1_in;
      h2_ff      <= h2_in;
      idx_ff     <= idx_in;
      is_new_ff  <= is_new_in;
      written_ff <= written_in;
      slot_ff    <= slot_in;
   end

   assign rsp_item.is_new       = is_new_ff;
   assign rsp_item.pool_written = written_ff;
   assign rsp_item.pool_slot    = bdrs_pkg::SLOT_W'(slot_ff);
   assign rsp_item.pool_fill    = bdrs_pkg::FILL_W'(pool_cnt_ff);

`ifndef SYNTHESIS
   a_written_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.pool_written |-> rsp_item.is_new)
      else $error("pool written for a key already seen");

   a_seen_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.is_new |-> rsp_item.pool_slot == '0)
      else $error("nonzero slot for a key already seen");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_cnt_ff <= bdrs_pkg::POOL_CNT_W'(bdrs_pkg::POOL_DEPTH))
      else $error("pool count beyond pool depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("block free or answering right after a transfer");
`endif

endmodule

[dv/dedup_sampler_checker.sv]
// checker for the bloom dedup reservoir sampler: watches all channels, predicts and compares
`timescale 1ns / 1ps

module dedup_sampler_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  bdrs_pkg::req_type           req_item,
   input  logic                        rsp_valid,
   input  bdrs_pkg::rsp_type           rsp_item,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [bdrs_pkg::CFG_W-1:0]  csr_data,
   output int unsigned                 outstanding,
   output int unsigned                 mismatches,
   output int unsigned                 new_keys,
   output int unsigned                 repeat_keys,
   output int unsigned                 pool_replacements
);

   logic [bdrs_pkg::FILTER_DEPTH-1:0] marked_bits;
   logic [bdrs_pkg::POOL_CNT_W-1:0]   fill_count;
   logic [bdrs_pkg::SEEN_W-1:0]       admitted_total;
   logic [bdrs_pkg::CFG_W-1:0]        probe_setting;
   bdrs_pkg::rsp_type                 sample_outcomes[$];

   function automatic logic [bdrs_pkg::HASH_W-1:0] mix_key(
      input logic [bdrs_pkg::WORD_W-1:0] word);
      logic [bdrs_pkg::WORD_W-1:0] v;
      v = word;
      v = v ^ (v >> bdrs_pkg::MIX_SHIFT);
      v = v * bdrs_pkg::MUL_A;
      v = v ^ (v >> bdrs_pkg::MIX_SHIFT);
      v = v * bdrs_pkg::MUL_B;
      v = v ^ (v >> bdrs_pkg::MIX_SHIFT);
      return v[bdrs_pkg::HASH_W-1:0];
   endfunction

   // updates the filter and pool bookkeeping for one key, returns the outcome
   function automatic bdrs_pkg::rsp_type admit_key(input bdrs_pkg::req_type item);
      logic [bdrs_pkg::HASH_W-1:0] h1;
      logic [bdrs_pkg::HASH_W-1:0] h2;
      logic [bdrs_pkg::HASH_W-1:0] pos;
      logic [bdrs_pkg::SEEN_W-1:0] pick;
      int unsigned                 probes;
      int                          i;
      bit                          all_marked;
      bdrs_pkg::rsp_type           outcome;
      if (probe_setting == 0)
         probes = 1;
      else if (probe_setting > bdrs_pkg::MAX_PROBES)
         probes = bdrs_pkg::MAX_PROBES;
      else
         probes = probe_setting;
      h1 = mix_key(bdrs_pkg::WORD_W'(item.device_key));
      h2 = mix_key(bdrs_pkg::WORD_W'(item.device_key) ^ bdrs_pkg::GOLDEN) | 32'd1;
      all_marked = 1'b1;
      for (i = 0; i < probes; i++) begin
         pos = h1 + i * h2;
         if (!marked_bits[pos[bdrs_pkg::FILTER_INDEX_BITS-1:0]])
            all_marked = 1'b0;
      end
      outcome = '0;
      if (all_marked) begin
         repeat_keys++;
      end else begin
         new_keys++;
         outcome.is_new = 1'b1;
         for (i = 0; i < probes; i++) begin
            pos = h1 + i * h2;
            marked_bits[pos[bdrs_pkg::FILTER_INDEX_BITS-1:0]] = 1'b1;
         end
         if (admitted_total != '1)
            admitted_total++;
         if (fill_count < bdrs_pkg::POOL_DEPTH) begin
            outcome.pool_written = 1'b1;
            outcome.pool_slot    = bdrs_pkg::SLOT_W'(fill_count);
            fill_count++;
         end else begin
            // full pool: replace only when the draw lands inside it
            pick = item.random_word % admitted_total;
            if (pick < bdrs_pkg::POOL_DEPTH) begin
               outcome.pool_written = 1'b1;
               outcome.pool_slot    = pick[bdrs_pkg::SLOT_W-1:0];
               pool_replacements++;
            end
         end
      end
      outcome.pool_fill = bdrs_pkg::FILL_W'(fill_count);
      return outcome;
   endfunction

   task automatic flag_mismatch(input string what, input bdrs_pkg::rsp_type want,
                                input bdrs_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"[%0t] %s: expected new=%0b written=%0b slot=%0d fill=%0d, ",
                   "got new=%0b written=%0b slot=%0d fill=%0d"},
                  $time, what, want.is_new, want.pool_written, want.pool_slot,
                  want.pool_fill, got.is_new, got.pool_written, got.pool_slot,
                  got.pool_fill);
   endtask

   always @(posedge clock) begin
      bdrs_pkg::rsp_type want;
      if (reset) begin
         marked_bits       = '0;
         fill_count        = '0;
         admitted_total    = '0;
         probe_setting     = bdrs_pkg::RESET_NUM_HASHES;
         sample_outcomes.delete();
         mismatches        = 0;
         new_keys          = 0;
         repeat_keys       = 0;
         pool_replacements = 0;
      end else begin
         if (csr_valid && csr_ready)
            probe_setting = csr_data;
         if (start && !busy)
            sample_outcomes.insert(sample_outcomes.size(), admit_key(req_item));
         if (rsp_valid) begin
            if (sample_outcomes.size() == 0) begin
               flag_mismatch("result with nothing pending", '0, rsp_item);
            end else begin
               want = sample_outcomes.pop_front();
               if (rsp_item.is_new !== want.is_new ||
                   rsp_item.pool_written !== want.pool_written ||
                   rsp_item.pool_slot !== want.pool_slot ||
                   rsp_item.pool_fill !== want.pool_fill)
                  flag_mismatch("result mismatch", want, rsp_item);
            end
         end
      end
      outstanding = sample_outcomes.size();
   end

endmodule

[dv/testbench.sv]
// testbench top: clock, reset, stimulus and verdict for the bloom dedup reservoir sampler
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned PHASE_ITEMS   = 212;
   localparam int unsigned PHASES        = 8;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned STEADY_PHASE  = 3;
   localparam int unsigned HISTORY_DEPTH = 64;
   // probe counts per phase, phase 0 in the low nibble; covers zero, one, eight and above
   localparam logic [PHASES*bdrs_pkg::CFG_W-1:0] PROBE_PLAN =
      {4'd3, 4'd2, 4'd4, 4'd9, 4'd1, 4'd15, 4'd8, 4'd0};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   bdrs_pkg::req_type             req_item = '0;
   logic                          rsp_valid;
   bdrs_pkg::rsp_type             rsp_item;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bdrs_pkg::CFG_W-1:0]    csr_data = bdrs_pkg::RESET_NUM_HASHES;

   int unsigned                   outstanding;
   int unsigned                   mismatches;
   int unsigned                   new_keys;
   int unsigned                   repeat_keys;
   int unsigned                   pool_replacements;
   int unsigned                   cycles = 0;
   int unsigned                   items_sent = 0;
   logic [bdrs_pkg::KEY_W-1:0]    key_history[$];

   bloom_dedup_reservoir_sampler DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dedup_sampler_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_valid         (rsp_valid),
      .rsp_item          (rsp_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .outstanding       (outstanding),
      .mismatches        (mismatches),
      .new_keys          (new_keys),
      .repeat_keys       (repeat_keys),
      .pool_replacements (pool_replacements)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input bdrs_pkg::req_type item, input int unsigned gap);
      if (gap > 0) begin
         start    <= 1'b0;
         req_item <= bdrs_pkg::req_type'({16'($urandom), $urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
      key_history.insert(key_history.size(), item.device_key);
      if (key_history.size() > HISTORY_DEPTH)
         void'(key_history.pop_front());
   endtask

   // gaps up to past the longest latency so start rises at every stage of the work
   function automatic int unsigned idle_gap(input bit steady);
      if (!steady && $urandom_range(0, 99) < 11)
         return $urandom_range(1, 90);
      return 0;
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_probes(input logic [bdrs_pkg::CFG_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      bdrs_pkg::req_type item;
      bdrs_pkg::req_type directed_q[$];
      int unsigned       phase;
      int unsigned       n;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, repeats of the same key, alternating bit patterns
      directed_q.insert(directed_q.size(), '{device_key: '0, random_word: '0});
      directed_q.insert(directed_q.size(), '{device_key: '0, random_word: '1});
      directed_q.insert(directed_q.size(), '{device_key: '1, random_word: '1});
      directed_q.insert(directed_q.size(), '{device_key: '1, random_word: '0});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'h5555_5555_5555, random_word: 32'h5555_5555});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'haaaa_aaaa_aaaa, random_word: 32'haaaa_aaaa});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'h5555_5555_5555, random_word: 32'haaaa_aaaa});
      directed_q.insert(directed_q.size(), '{device_key: 48'd1, random_word: 32'd1});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'h8000_0000_0000, random_word: 32'h8000_0000});
      directed_q.insert(directed_q.size(), '{device_key: 48'd1, random_word: 32'd49});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'h0123_4567_89ab, random_word: 32'd50});
      directed_q.insert(directed_q.size(),
                        '{device_key: 48'h0123_4567_89ab, random_word: 32'd50});
      foreach (directed_q[k])
         send_item(directed_q[k], idle_gap(1'b0));

      for (phase = 0; phase < PHASES; phase++) begin
         write_probes(PROBE_PLAN[phase*bdrs_pkg::CFG_W +: bdrs_pkg::CFG_W]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  if (key_history.size() != 0)
                     item.device_key = key_history[$urandom_range(0, key_history.size() - 1)];
                  else
                     item.device_key = {16'($urandom), $urandom};
               end
               4: item.device_key = 48'd1 << $urandom_range(0, bdrs_pkg::KEY_W - 1);
               5: item.device_key = ~(48'd1 << $urandom_range(0, bdrs_pkg::KEY_W - 1));
               default: item.device_key = {16'($urandom), $urandom};
            endcase
            case ($urandom_range(0, 7))
               0: item.random_word = $urandom_range(0, 120);
               1: item.random_word = '1;
               2: item.random_word = '0;
               default: item.random_word = $urandom;
            endcase
            send_item(item, idle_gap(phase == STEADY_PHASE));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("%0d items over %0d probe settings plus the reset setting", items_sent, PHASES);
      $display("%0d new keys, %0d repeats, %0d pool replacements after the pool filled",
               new_keys, repeat_keys, pool_replacements);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/bdrs_pkg.sv
rtl/core/bdrs_ram.sv
rtl/core/bdrs_hash.sv
rtl/core/bdrs_mod.sv
rtl/core/bloom_dedup_reservoir_sampler.sv
dv/dedup_sampler_checker.sv
dv/testbench.sv
